// ===== sv/psbe_pkg.sv =====
// Shared types, constants and helpers for the point set box expander.
package psbe_pkg;

  localparam int MaxPoints = 64;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int PointW    = 96;

  localparam logic signed [31:0] DepthCut = 32'sd22938;
  localparam logic signed [31:0] PosMax   = 32'sh7FFFFFFF;
  localparam logic signed [31:0] NegMax   = 32'sh80000000;

  localparam logic CfgSizeIncrease = 1'b0;
  localparam logic CfgDepthOffset  = 1'b1;

  // Job handed from the loader to the emitter at the end of a set.
  typedef struct packed {
    logic [CntW-1:0]    count;
    logic signed [31:0] min_x;
    logic signed [31:0] max_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_y;
    logic               ovf;
  } job_t;

  // Saturate a 34-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh07FFFFFFF) r = PosMax;
    else if (v < -34'sh080000000) r = NegMax;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== sv/psbe_ram.sv =====
// Generic single-port-write, registered-read RAM.
module psbe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== sv/psbe_front.sv =====
// Loader: stores points, tracks the box and posts a job at set end.
module psbe_front import psbe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_point_x,
  input  logic signed [31:0]   in_point_y,
  input  logic signed [31:0]   in_point_z,
  input  logic                 in_set_end,
  input  logic                 busy,
  output logic                 wr_en,
  output logic [AddrW-1:0]     wr_addr,
  output logic [PointW-1:0]    wr_data,
  output logic                 job_valid,
  output job_t                 job
);
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic signed [31:0] mnx_r, mnx_nxt, mxx_r, mxx_nxt, mny_r, mny_nxt, mxy_r, mxy_nxt;
  logic               ovf_r, ovf_nxt;
  logic               acc, room;

  // A new set may not write the store while the previous one is emitted.
  assign in_stall = busy;
  assign acc      = in_valid && !busy;
  assign room     = cnt_r < CntW'(MaxPoints);
  assign wr_en    = acc && room;
  assign wr_addr  = cnt_r[AddrW-1:0];
  assign wr_data  = {in_point_x, in_point_y, in_point_z};

  always_comb begin
    cnt_nxt = cnt_r; ovf_nxt = ovf_r;
    mnx_nxt = mnx_r; mxx_nxt = mxx_r; mny_nxt = mny_r; mxy_nxt = mxy_r;
    if (acc) begin
      if (room) begin
        cnt_nxt = cnt_r + 1'b1;
        if (in_point_x < mnx_r) mnx_nxt = in_point_x;
        if (in_point_x > mxx_r) mxx_nxt = in_point_x;
        if (in_point_y < mny_r) mny_nxt = in_point_y;
        if (in_point_y > mxy_r) mxy_nxt = in_point_y;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    job.count = cnt_nxt; job.min_x = mnx_nxt; job.max_x = mxx_nxt;
    job.min_y = mny_nxt; job.max_y = mxy_nxt; job.ovf = ovf_nxt;
  end

  assign job_valid = acc && in_set_end;

  // Hold set state; clear it once the job is posted.
  always_ff @(posedge clk) begin
    if (!rst_n || job_valid) begin
      cnt_r <= '0; ovf_r <= 1'b0;
      mnx_r <= PosMax; mxx_r <= NegMax; mny_r <= PosMax; mxy_r <= NegMax;
    end else begin
      cnt_r <= cnt_nxt; ovf_r <= ovf_nxt;
      mnx_r <= mnx_nxt; mxx_r <= mxx_nxt; mny_r <= mny_nxt; mxy_r <= mxy_nxt;
    end
  end
endmodule

// ===== sv/psbe_back.sv =====
// Emitter: computes both scales serially, then moves and emits each point.
module psbe_back import psbe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  job_t                job,
  output logic                busy,
  input  logic signed [31:0]  size_increase,
  input  logic signed [31:0]  depth_offset,
  output logic [AddrW-1:0]    rd_addr,
  input  logic [PointW-1:0]   rd_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_moved_x,
  output logic signed [31:0]  out_moved_y,
  output logic signed [31:0]  out_moved_z,
  output logic                out_run_end,
  output logic                out_outcome,
  output logic                out_dropped
);
  localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_RD = 3'd2, S_D2 = 3'd3,
                         S_MUL = 3'd4, S_RND = 3'd5, S_FIN = 3'd6, S_OUT = 3'd7;
  localparam logic [6:0] DivStart = 7'd127;

  logic [2:0]         st_r, st_nxt;
  job_t               job_r;
  logic               deg_r, axis_r;
  logic [CntW-1:0]    k_r;
  // Divider: restoring, one quotient bit a cycle, 64-bit dividend magnitude.
  logic [6:0]         dcnt_r;
  logic [63:0]        dvd_r;
  logic [33:0]        rem_r;
  logic [32:0]        den_r;
  logic               dneg_r;
  // Scales kept as Q.30 magnitude and sign.
  logic [62:0]        smx_r, smy_r;
  logic               snx_r, sny_r;
  logic signed [33:0] wx, wy, nw;
  logic [33:0]        nwmag, trial;
  // Move datapath.
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [33:0] sumx_r, sumy_r;
  logic signed [34:0] d2x, d2y;
  logic [32:0]        dmx_r, dmy_r;
  logic               pnx_r, pny_r;
  logic [64:0]        plx_r, ply_r;
  logic [63:0]        phx_r, phy_r;
  logic [33:0]        rqx_r, rqy_r;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic               ov_r;

  assign wx = 34'(job_r.max_x) - 34'(job_r.min_x);
  assign wy = 34'(job_r.max_y) - 34'(job_r.min_y);
  assign nw = (axis_r ? wy : wx) + 34'(size_increase);
  assign nwmag = nw[33] ? 34'(-nw) : nw;
  assign trial = {rem_r[32:0], dvd_r[63]};
  assign busy = st_r != S_IDLE;
  assign rd_addr = k_r[AddrW-1:0];

  // Doubled offset of the point from the box center.
  assign d2x = (35'(px_r) <<< 1) - 35'(sumx_r);
  assign d2y = (35'(py_r) <<< 1) - 35'(sumy_r);

  // Add the signed rounded product to the center sum and halve, half away from zero.
  function automatic logic signed [31:0] fin(input logic signed [33:0] sum,
                                             input logic neg,
                                             input logic [33:0] rq);
    logic signed [34:0] r2;
    logic [34:0] m;
    r2 = 35'(sum) + (neg ? -35'(rq) : 35'(rq));
    m = r2[34] ? 35'(-r2) : 35'(r2);
    m = (m + 35'd1) >> 1;
    return sat34(r2[34] ? -34'(m) : 34'(m));
  endfunction

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (job_valid) st_nxt = S_DIV;
      S_DIV:  if (dcnt_r == 7'd0 && axis_r) st_nxt = S_RD;
      S_RD:   st_nxt = S_D2;
      S_D2:   st_nxt = S_MUL;
      S_MUL:  st_nxt = S_RND;
      S_RND:  st_nxt = S_FIN;
      S_FIN:  st_nxt = S_OUT;
      S_OUT:  if (!ov_r || !out_stall)
                st_nxt = (k_r == job_r.count) ? S_IDLE : S_RD;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (st_r == S_FIN) ov_r <= 1'b1;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (job_valid) begin
        job_r <= job; axis_r <= 1'b0; k_r <= '0; dcnt_r <= DivStart;
      end
      S_DIV: begin
        if (dcnt_r == DivStart) begin
          deg_r  <= (wx <= 0) || (wy <= 0);
          den_r  <= 33'(axis_r ? wy : wx);
          dneg_r <= nw[33];
          dvd_r  <= {nwmag[33:0], 30'd0};
          rem_r  <= '0;
          dcnt_r <= 7'd65;
        end else if (dcnt_r == 7'd1) begin
          // Rounding: add one if remainder*2 >= den.
          if ({rem_r, 1'b0} >= {2'b0, den_r}) dvd_r <= dvd_r + 64'd1;
          dcnt_r <= 7'd0;
        end else if (dcnt_r == 7'd0) begin
          if (axis_r) begin
            smy_r <= dvd_r[62:0]; sny_r <= dneg_r;
          end else begin
            smx_r <= dvd_r[62:0]; snx_r <= dneg_r;
          end
          axis_r <= 1'b1; dcnt_r <= DivStart;
        end else begin
          if (trial >= {1'b0, den_r}) begin
            rem_r <= trial - {1'b0, den_r}; dvd_r <= {dvd_r[62:0], 1'b1};
          end else begin
            rem_r <= trial; dvd_r <= {dvd_r[62:0], 1'b0};
          end
          dcnt_r <= dcnt_r - 7'd1;
        end
      end
      S_RD: begin
        px_r <= rd_data[95:64]; py_r <= rd_data[63:32]; pz_r <= rd_data[31:0];
        k_r  <= k_r + 1'b1;
        sumx_r <= 34'(job_r.min_x) + 34'(job_r.max_x);
        sumy_r <= 34'(job_r.min_y) + 34'(job_r.max_y);
      end
      // Split the offsets into magnitude and product sign.
      S_D2: begin
        dmx_r <= d2x[34] ? 33'(-d2x) : 33'(d2x);
        dmy_r <= d2y[34] ? 33'(-d2y) : 33'(d2y);
        pnx_r <= d2x[34] ^ snx_r;
        pny_r <= d2y[34] ^ sny_r;
      end
      // Partial products on the low and high halves of the scale.
      S_MUL: begin
        plx_r <= dmx_r * smx_r[31:0];
        phx_r <= dmx_r * smx_r[62:32];
        ply_r <= dmy_r * smy_r[31:0];
        phy_r <= dmy_r * smy_r[62:32];
      end
      // Join the halves and round the magnitude by 2^30.
      S_RND: begin
        rqx_r <= 34'((66'(plx_r) + {phx_r[33:0], 32'd0} + (66'd1 << 29)) >> 30);
        rqy_r <= 34'((66'(ply_r) + {phy_r[33:0], 32'd0} + (66'd1 << 29)) >> 30);
      end
      S_FIN: begin
        if (deg_r) begin
          ox_r <= px_r; oy_r <= py_r; oz_r <= pz_r;
        end else begin
          ox_r <= fin(sumx_r, pnx_r, rqx_r);
          oy_r <= fin(sumy_r, pny_r, rqy_r);
          oz_r <= sat34(34'((pz_r > DepthCut) ? pz_r - DepthCut : pz_r)
                        + 34'(depth_offset));
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = ov_r;
  assign out_moved_x = ox_r;
  assign out_moved_y = oy_r;
  assign out_moved_z = oz_r;
  assign out_run_end = k_r == job_r.count;
  assign out_outcome = deg_r;
  assign out_dropped = job_r.ovf;
endmodule

// ===== sv/point_set_box_expand.sv =====
// Top level of the point set box expander.
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall  | point_x, point_y, point_z, set_end
//  out_    | out | out_valid/out_stall| moved_x/y/z, run_end, outcome, dropped
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
// Loading takes one point per cycle while in_stall is low. At set end two
// serial divider passes form the scales, then each point goes in turn
// through the store read, offset, multiplier, rounding, final and output
// states; output holds while the result stalls. Input stalls while the
// scales form and a set is emitted. Reset is synchronous, active low.
module point_set_box_expand import psbe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic               in_set_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_moved_x,
  output logic signed [31:0] out_moved_y,
  output logic signed [31:0] out_moved_z,
  output logic               out_run_end,
  output logic               out_outcome,
  output logic               out_dropped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic signed [31:0] cfg_data
);
  logic signed [31:0] inc_r, dofs_r;
  logic               busy, wr_en, job_valid;
  logic [AddrW-1:0]   wr_addr, rd_addr;
  logic [PointW-1:0]  wr_data, rd_data;
  job_t               job;

  assign cfg_ready = 1'b1;

  // Write configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r <= '0; dofs_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CfgSizeIncrease) inc_r <= cfg_data;
      if (cfg_index == CfgDepthOffset)  dofs_r <= cfg_data;
    end
  end

  psbe_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_point_x, .in_point_y, .in_point_z,
    .in_set_end, .busy, .wr_en, .wr_addr, .wr_data, .job_valid, .job
  );

  psbe_ram #(.Width(PointW), .Depth(MaxPoints)) u_store (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  psbe_back u_back (
    .clk, .rst_n, .job_valid, .job, .busy, .size_increase(inc_r),
    .depth_offset(dofs_r), .rd_addr, .rd_data, .out_valid, .out_stall,
    .out_moved_x, .out_moved_y, .out_moved_z, .out_run_end, .out_outcome,
    .out_dropped
  );
endmodule
